[hdl/line_sensor_threshold_calibrator_unit_defines.svh]
// assertion macros for the line sensor threshold calibrator checker
// no dependencies; included by the checker file
`ifndef LINE_SENSOR_THRESHOLD_CALIBRATOR_UNIT_DEFINES_SVH
`define LINE_SENSOR_THRESHOLD_CALIBRATOR_UNIT_DEFINES_SVH

// same-cycle implication, skipped while reset is high
`define LSTC_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("lstc check failed");

// next-cycle implication, skipped while reset is high
`define LSTC_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("lstc check failed");

`endif

[hdl/lstc_pkg.sv]
// shared types and constants for the line sensor threshold calibrator
// no dependencies
`default_nettype none

package lstc_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int SENSORS     = 3;

  localparam int IDX_LEFT   = 0;
  localparam int IDX_CENTER = 1;
  localparam int IDX_RIGHT  = 2;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SAMPLE_BITS:0]   sum_t;

  typedef enum logic {
    STAGE_LOW  = 1'b0,
    STAGE_HIGH = 1'b1
  } stage_t;

  typedef struct packed {
    sample_t [SENSORS-1:0] sample;
    logic    [SENSORS-1:0] press;
  } item_t;

  typedef struct packed {
    logic    [SENSORS-1:0] line;
    stage_t                stage;
    sample_t [SENSORS-1:0] level;
  } result_t;

endpackage

`default_nettype wire

[hdl/line_sensor_threshold_calibrator_unit.sv]
// Two-point threshold calibrator for three line sensors. Each item carries three
// samples and three button levels; a new press edge captures the sample of the
// highest-priority pressed sensor as its low point; the next edge takes the picked
// sensor's sample as its high point and sets its threshold to the floor of the mean.
// One result leaves per item; one item is taken every clock cycle unless the output
// stalls. Items pass the input register, the combinational update logic and the
// result register. Ready runs back combinationally through both registers.
// Depends on lstc_pkg, lstc_in_stage, lstc_cal_core and lstc_out_stage.
`default_nettype none

module line_sensor_threshold_calibrator_unit (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire lstc_pkg::sample_t       sample_left,
  input  wire lstc_pkg::sample_t       sample_center,
  input  wire lstc_pkg::sample_t       sample_right,
  input  wire logic                    press_left,
  input  wire logic                    press_center,
  input  wire logic                    press_right,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         line_left,
  output logic                         line_center,
  output logic                         line_right,
  output logic                         stage_now,
  output lstc_pkg::sample_t            level_left,
  output lstc_pkg::sample_t            level_center,
  output lstc_pkg::sample_t            level_right
);

  lstc_pkg::item_t   item;
  lstc_pkg::item_t   item_q;
  lstc_pkg::result_t res;
  lstc_pkg::result_t res_q;
  logic              s_valid;
  logic              up_ready;
  logic              adv;

  always_comb begin
    item.sample[lstc_pkg::IDX_LEFT]   = sample_left;
    item.sample[lstc_pkg::IDX_CENTER] = sample_center;
    item.sample[lstc_pkg::IDX_RIGHT]  = sample_right;
    item.press[lstc_pkg::IDX_LEFT]    = press_left;
    item.press[lstc_pkg::IDX_CENTER]  = press_center;
    item.press[lstc_pkg::IDX_RIGHT]   = press_right;
  end

  assign adv = s_valid && up_ready;

  lstc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .item       (item),
    .valid_q    (s_valid),
    .item_q     (item_q),
    .down_ready (up_ready)
  );

  lstc_cal_core u_core (
    .clk  (clk),
    .rst  (rst),
    .item (item_q),
    .adv  (adv),
    .res  (res)
  );

  lstc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (s_valid),
    .up_ready  (up_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_q     (res_q)
  );

  assign line_left    = res_q.line[lstc_pkg::IDX_LEFT];
  assign line_center  = res_q.line[lstc_pkg::IDX_CENTER];
  assign line_right   = res_q.line[lstc_pkg::IDX_RIGHT];
  assign stage_now    = res_q.stage;
  assign level_left   = res_q.level[lstc_pkg::IDX_LEFT];
  assign level_center = res_q.level[lstc_pkg::IDX_CENTER];
  assign level_right  = res_q.level[lstc_pkg::IDX_RIGHT];

endmodule

`default_nettype wire

[hdl/lstc_in_stage.sv]
// input register stage: holds one accepted item for the calibration logic
// depends on lstc_pkg
`default_nettype none

module lstc_in_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire lstc_pkg::item_t item,
  output logic                valid_q,
  output lstc_pkg::item_t     item_q,
  input  wire logic           down_ready
);

  assign in_ready = !valid_q || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_ready) begin
      valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q <= item;
    end
  end

endmodule

`default_nettype wire

[hdl/lstc_cal_core.sv]
// calibration state and update logic: button edge, two-point capture,
// threshold mean and line compare; depends on lstc_pkg
`default_nettype none

module lstc_cal_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire lstc_pkg::item_t item,
  input  wire logic            adv,
  output lstc_pkg::result_t    res
);

  logic                                      prior_any;
  lstc_pkg::stage_t                          stage;
  lstc_pkg::sample_t [lstc_pkg::SENSORS-1:0] low_pts;
  lstc_pkg::sample_t [lstc_pkg::SENSORS-1:0] high_pts;
  lstc_pkg::sample_t [lstc_pkg::SENSORS-1:0] thr;

  logic                                      any_press;
  logic                                      press_edge;
  logic              [lstc_pkg::SENSORS-1:0] sel;
  lstc_pkg::stage_t                          stage_next;
  lstc_pkg::sample_t [lstc_pkg::SENSORS-1:0] low_next;
  lstc_pkg::sample_t [lstc_pkg::SENSORS-1:0] high_next;
  lstc_pkg::sample_t [lstc_pkg::SENSORS-1:0] thr_next;

  assign any_press  = |item.press;
  assign press_edge = any_press && !prior_any;

  // priority pick: left, then center, then right
  always_comb begin
    logic taken;
    taken = 1'b0;
    for (int i = 0; i < lstc_pkg::SENSORS; i++) begin
      sel[i] = item.press[i] && !taken;
      taken  = taken || item.press[i];
    end
  end

  always_comb begin
    lstc_pkg::sum_t sum;
    stage_next = press_edge
               ? ((stage == lstc_pkg::STAGE_LOW) ? lstc_pkg::STAGE_HIGH : lstc_pkg::STAGE_LOW)
               : stage;
    for (int i = 0; i < lstc_pkg::SENSORS; i++) begin
      sum         = {1'b0, low_pts[i]} + {1'b0, item.sample[i]};
      low_next[i] = low_pts[i];
      high_next[i] = high_pts[i];
      thr_next[i] = thr[i];
      if (press_edge && sel[i]) begin
        if (stage == lstc_pkg::STAGE_LOW) begin
          low_next[i] = item.sample[i];
        end else begin
          high_next[i] = item.sample[i];
          thr_next[i]  = sum[lstc_pkg::SAMPLE_BITS:1];
        end
      end
    end
  end

  // line bits from the updated points; compare inverts unless high > low
  always_comb begin
    for (int i = 0; i < lstc_pkg::SENSORS; i++) begin
      res.line[i]  = (high_next[i] > low_next[i]) ? (item.sample[i] > thr_next[i])
                                                  : (item.sample[i] < thr_next[i]);
      res.level[i] = thr_next[i];
    end
    res.stage = stage_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prior_any <= 1'b0;
      stage     <= lstc_pkg::STAGE_LOW;
      low_pts   <= '1;
      high_pts  <= '0;
      thr       <= '0;
    end else if (adv) begin
      prior_any <= any_press;
      stage     <= stage_next;
      low_pts   <= low_next;
      high_pts  <= high_next;
      thr       <= thr_next;
    end
  end

endmodule

`default_nettype wire

[hdl/lstc_out_stage.sv]
// result register stage: holds one finished result until it is taken
// depends on lstc_pkg
`default_nettype none

module lstc_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire lstc_pkg::result_t res,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output lstc_pkg::result_t      res_q
);

  assign up_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      res_q <= res;
    end
  end

endmodule

`default_nettype wire

[hdl/lstc_checker.sv]
// port-level checks for the calibrator, bound to the top level
// depends on lstc_pkg and the assertion macro header
`default_nettype none
`include "line_sensor_threshold_calibrator_unit_defines.svh"

module lstc_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              stage_now,
  input wire lstc_pkg::sample_t level_left
);

  // a result stays offered until taken
  `LSTC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // a stalled result keeps its fields
  `LSTC_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(level_left) && $stable(stage_now))

  // input stalls only when the result register is full
  `LSTC_ASSERT_NOW(a_stall_full, clk, rst, !in_ready, out_valid)

  // an accepted item has a result on offer once it has passed the input and result registers
  `LSTC_ASSERT_NEXT(a_latency, clk, rst, in_valid && in_ready, ##1 out_valid)

endmodule

bind line_sensor_threshold_calibrator_unit lstc_checker u_lstc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .stage_now  (stage_now),
  .level_left (level_left)
);

`default_nettype wire

[bench/lstc_result_checker.sv]
// checker for the line sensor threshold calibrator: watches both channels, keeps its
// own copy of the calibration state, and compares every result with the expected one
// depends on lstc_pkg
module lstc_result_checker
  import lstc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_ready,
  input  sample_t sample_left,
  input  sample_t sample_center,
  input  sample_t sample_right,
  input  logic    press_left,
  input  logic    press_center,
  input  logic    press_right,
  input  logic    out_valid,
  input  logic    out_ready,
  input  logic    line_left,
  input  logic    line_center,
  input  logic    line_right,
  input  logic    stage_now,
  input  sample_t level_left,
  input  sample_t level_center,
  input  sample_t level_right,
  output int      errors,
  output int      pending,
  output int      compared,
  output int      captures
);

  logic    was_pressed;
  stage_t  cal_stage;
  sample_t low_pt  [SENSORS];
  sample_t high_pt [SENSORS];
  sample_t thresh  [SENSORS];

  result_t expected_results [$];

  initial begin
    errors   = 0;
    pending  = 0;
    compared = 0;
    captures = 0;
  end

  function automatic result_t calibrate_and_classify(input sample_t [SENSORS-1:0] smp,
                                                     input logic [SENSORS-1:0] btn);
    result_t r;
    int      pick;
    sum_t    total;
    if (|btn && !was_pressed) begin
      pick = btn[IDX_LEFT] ? IDX_LEFT : (btn[IDX_CENTER] ? IDX_CENTER : IDX_RIGHT);
      captures++;
      if (cal_stage == STAGE_LOW) begin
        low_pt[pick] = smp[pick];
        cal_stage    = STAGE_HIGH;
      end else begin
        high_pt[pick] = smp[pick];
        total         = sum_t'(low_pt[pick]) + sum_t'(high_pt[pick]);
        thresh[pick]  = total[SAMPLE_BITS:1];
        cal_stage     = STAGE_LOW;
      end
    end
    was_pressed = |btn;
    for (int i = 0; i < SENSORS; i++) begin
      if (high_pt[i] > low_pt[i]) r.line[i] = smp[i] > thresh[i];
      else r.line[i] = smp[i] < thresh[i];
      r.level[i] = thresh[i];
    end
    r.stage = cal_stage;
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : watch
    sample_t [SENSORS-1:0] smp;
    logic    [SENSORS-1:0] btn;
    result_t               want;
    if (rst) begin
      was_pressed = 1'b0;
      cal_stage   = STAGE_LOW;
      for (int i = 0; i < SENSORS; i++) begin
        low_pt[i]  = '1;
        high_pt[i] = '0;
        thresh[i]  = '0;
      end
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no item outstanding");
          errors++;
        end else begin
          want = expected_results.pop_front();
          compared++;
          check_field("line_left", want.line[IDX_LEFT], line_left);
          check_field("line_center", want.line[IDX_CENTER], line_center);
          check_field("line_right", want.line[IDX_RIGHT], line_right);
          check_field("stage_now", want.stage, stage_now);
          check_field("level_left", want.level[IDX_LEFT], level_left);
          check_field("level_center", want.level[IDX_CENTER], level_center);
          check_field("level_right", want.level[IDX_RIGHT], level_right);
        end
      end
      if (in_valid && in_ready) begin
        smp[IDX_LEFT]   = sample_left;
        smp[IDX_CENTER] = sample_center;
        smp[IDX_RIGHT]  = sample_right;
        btn[IDX_LEFT]   = press_left;
        btn[IDX_CENTER] = press_center;
        btn[IDX_RIGHT]  = press_right;
        expected_results.push_back(calibrate_and_classify(smp, btn));
      end
    end
    pending = expected_results.size();
  end

endmodule

[bench/testbench.sv]
// top of the calibrator bench: clock, reset, item stimulus and handshake idling
// the checker instance predicts and compares; this module reports the verdict
// depends on lstc_pkg, line_sensor_threshold_calibrator_unit and lstc_result_checker
module testbench;
  import lstc_pkg::*;

  localparam int LIMIT        = 200000;
  localparam int PHASE_ITEMS  = 270;

  logic    clk           = 1'b0;
  logic    rst           = 1'b1;
  logic    in_valid      = 1'b0;
  logic    in_ready;
  sample_t sample_left   = '0;
  sample_t sample_center = '0;
  sample_t sample_right  = '0;
  logic    press_left    = 1'b0;
  logic    press_center  = 1'b0;
  logic    press_right   = 1'b0;
  logic    out_valid;
  logic    out_ready     = 1'b0;
  logic    line_left;
  logic    line_center;
  logic    line_right;
  logic    stage_now;
  sample_t level_left;
  sample_t level_center;
  sample_t level_right;

  int errors;
  int pending;
  int compared;
  int captures;
  int cycles      = 0;
  int items_sent  = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  always #10 clk = ~clk;

  line_sensor_threshold_calibrator_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_left  (sample_left),
    .sample_center(sample_center),
    .sample_right (sample_right),
    .press_left   (press_left),
    .press_center (press_center),
    .press_right  (press_right),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .line_left    (line_left),
    .line_center  (line_center),
    .line_right   (line_right),
    .stage_now    (stage_now),
    .level_left   (level_left),
    .level_center (level_center),
    .level_right  (level_right)
  );

  lstc_result_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_left  (sample_left),
    .sample_center(sample_center),
    .sample_right (sample_right),
    .press_left   (press_left),
    .press_center (press_center),
    .press_right  (press_right),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .line_left    (line_left),
    .line_center  (line_center),
    .line_right   (line_right),
    .stage_now    (stage_now),
    .level_left   (level_left),
    .level_center (level_center),
    .level_right  (level_right),
    .errors       (errors),
    .pending      (pending),
    .compared     (compared),
    .captures     (captures)
  );

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_item(input sample_t l, input sample_t c, input sample_t r,
                           input logic pl, input logic pc, input logic pr);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    sample_left   <= l;
    sample_center <= c;
    sample_right  <= r;
    press_left    <= pl;
    press_center  <= pc;
    press_right   <= pr;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    items_sent++;
  endtask

  // hold the sender off until every outstanding result has drained
  task automatic drain;
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic sample_t pick_sample;
    int roll;
    roll = $urandom_range(99);
    if (roll < 15) begin
      case ($urandom_range(5))
        0: return 12'd0;
        1: return 12'd4095;
        2: return 12'd1;
        3: return 12'd4094;
        4: return 12'd2047;
        default: return 12'd2048;
      endcase
    end
    return sample_t'($urandom_range(4095));
  endfunction

  // mostly clean press and release sequences, some holds and joining buttons
  function automatic logic [2:0] next_buttons(input logic [2:0] prev);
    int roll;
    roll = $urandom_range(99);
    if (prev == 3'b000) return (roll < 60) ? 3'($urandom_range(7, 1)) : 3'b000;
    if (roll < 50) return 3'b000;
    if (roll < 75) return prev;
    return 3'($urandom_range(7, 1));
  endfunction

  initial begin : stimulus
    logic [2:0] btn;
    btn = 3'b000;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset thresholds, extremes of the samples
    send_item(12'd0, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0);
    send_item(12'd4095, 12'd4095, 12'd4095, 1'b0, 1'b0, 1'b0);
    // low then high on the left, with a hold in between
    send_item(12'd1000, 12'd5, 12'd6, 1'b1, 1'b0, 1'b0);
    send_item(12'd3900, 12'd7, 12'd8, 1'b1, 1'b0, 1'b0);
    send_item(12'd1000, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0);
    send_item(12'd3000, 12'd0, 12'd0, 1'b1, 1'b0, 1'b0);
    send_item(12'd2001, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0);
    send_item(12'd1999, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0);
    send_item(12'd2000, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0);
    // all three at once, left wins
    send_item(12'd4095, 12'd500, 12'd600, 1'b1, 1'b1, 1'b1);
    send_item(12'd0, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0);
    // center and right, center wins; high point from another sensor, below low
    send_item(12'd0, 12'd0, 12'd4095, 1'b0, 1'b1, 1'b1);
    send_item(12'd100, 12'd2046, 12'd2048, 1'b0, 1'b0, 1'b0);
    // right alone, then center joins while held, then release
    send_item(12'd0, 12'd0, 12'd4095, 1'b0, 1'b0, 1'b1);
    send_item(12'd0, 12'd10, 12'd20, 1'b0, 1'b1, 1'b1);
    send_item(12'd0, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0);
    send_item(12'd0, 12'd0, 12'd4095, 1'b0, 1'b0, 1'b1);
    send_item(12'd0, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0);
    // equal points on the left
    send_item(12'd777, 12'd0, 12'd0, 1'b1, 1'b0, 1'b0);
    send_item(12'd0, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0);
    send_item(12'd777, 12'd0, 12'd0, 1'b1, 1'b0, 1'b0);
    send_item(12'd776, 12'd778, 12'd0, 1'b0, 1'b0, 1'b0);
    // largest sum on the center
    send_item(12'd0, 12'd4095, 12'd0, 1'b0, 1'b1, 1'b0);
    send_item(12'd0, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0);
    send_item(12'd0, 12'd4095, 12'd0, 1'b0, 1'b1, 1'b0);

    for (int phase = 0; phase < 3; phase++) begin
      drain();
      case (phase)
        0: begin
          tx_idle_pct = 26;
          rx_idle_pct = 78;
        end
        1: begin
          tx_idle_pct = 78;
          rx_idle_pct = 26;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        btn = next_buttons(btn);
        send_item(pick_sample(), pick_sample(), pick_sample(), btn[0], btn[1], btn[2]);
      end
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d items with %0d calibration captures, %0d results compared",
             items_sent, captures, compared);
    $display("three handshake phases: slow receiver, slow sender, no idling");
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
